// ===== design/sktbl_pkg.sv =====
// sktbl_pkg: shared sizes, request and status codes, cell control struct
// used by the sorted key table cells, the resolver and the top level
package sktbl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;

  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_RSVD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctrl_t;

  // resolver result
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] rank;
  } lookup_t;

endpackage

// ===== design/sktbl_cell.sv =====
// sktbl_cell: one table cell holding a key/value pair, its compare flags
// and the shift path to its neighbors; depends on sktbl_pkg
module sktbl_cell (
  input  logic                              clk,
  input  sktbl_pkg::cell_ctrl_t             ctrl,
  input  logic                              occ,
  input  logic signed [sktbl_pkg::KEY_W-1:0] req_key,
  input  logic signed [sktbl_pkg::VAL_W-1:0] req_val,
  input  logic                              left_lt,
  input  logic signed [sktbl_pkg::KEY_W-1:0] left_key,
  input  logic signed [sktbl_pkg::VAL_W-1:0] left_val,
  input  logic signed [sktbl_pkg::KEY_W-1:0] right_key,
  input  logic signed [sktbl_pkg::VAL_W-1:0] right_val,
  output logic                              lt,
  output logic                              eq,
  output logic signed [sktbl_pkg::KEY_W-1:0] cell_key,
  output logic signed [sktbl_pkg::VAL_W-1:0] cell_val
);

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt <= occ & (cell_key < req_key);
      eq <= occ & (cell_key == req_key);
    end
  end

  // cells at or above the rank shift (up on insert, down on remove); an insert puts the new pair at the rank
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      cell_key <= left_lt ? req_key : left_key;
      cell_val <= left_lt ? req_val : left_val;
    end else if (ctrl.rem && !lt) begin
      cell_key <= right_key;
      cell_val <= right_val;
    end
  end

endmodule

// ===== design/sktbl_resolve.sv =====
// sktbl_resolve: turns the per-cell compare flags into rank, hit and the
// matching value; depends on sktbl_pkg
module sktbl_resolve (
  input  logic [sktbl_pkg::CAPACITY-1:0]                        lt,
  input  logic [sktbl_pkg::CAPACITY-1:0]                        eq,
  input  logic [sktbl_pkg::CAPACITY-1:0]                        occ,
  input  logic [sktbl_pkg::CAPACITY-1:0][sktbl_pkg::VAL_W-1:0] vals,
  input  logic [sktbl_pkg::CNT_W-1:0]                           fill,
  output sktbl_pkg::lookup_t                                    lookup,
  output logic [sktbl_pkg::VAL_W-1:0]                           hit_val
);

  logic [sktbl_pkg::CAPACITY-1:0] prev_lt;
  logic [sktbl_pkg::CAPACITY-1:0] edge_bit;
  logic [sktbl_pkg::IDX_W-1:0]    idx;

  assign prev_lt  = {lt[sktbl_pkg::CAPACITY-2:0], 1'b1};
  // first occupied cell whose key is not smaller
  assign edge_bit = occ & ~lt & prev_lt;

  always_comb begin
    idx     = '0;
    hit_val = '0;
    for (int i = 0; i < sktbl_pkg::CAPACITY; i++) begin
      if (edge_bit[i]) idx = idx | sktbl_pkg::IDX_W'(i);
      if (eq[i]) hit_val = hit_val | vals[i];
    end
  end

  assign lookup.hit  = |eq;
  assign lookup.rank = (|edge_bit) ? sktbl_pkg::CNT_W'(idx) : fill;

endmodule

// ===== design/sorted_key_table.sv =====
// sorted_key_table: sorted key/value table built from a row of cells
// a request passes the compare state and then the shift/commit state of the cell row;
// the result is registered at commit, and no new request is taken until the table is back in idle
// a waiting result holds the commit cycle until it is taken
// reset clears the entry count and control; cell contents stay undefined until written
module sorted_key_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        req_type,
  input  logic signed [sktbl_pkg::KEY_W-1:0] key,
  input  logic signed [sktbl_pkg::VAL_W-1:0] entry_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic                              found,
  output logic signed [sktbl_pkg::VAL_W-1:0] value_out,
  output logic [sktbl_pkg::POS_W-1:0]        position,
  output logic [sktbl_pkg::POS_W-1:0]        entry_count
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [1:0]                          req;
  logic signed [sktbl_pkg::KEY_W-1:0]  req_key;
  logic signed [sktbl_pkg::VAL_W-1:0]  req_val;
  logic [sktbl_pkg::CNT_W-1:0]         fill, fill_next;

  logic [sktbl_pkg::CAPACITY-1:0]                        occ, lt, eq;
  logic [sktbl_pkg::CAPACITY-1:0][sktbl_pkg::KEY_W-1:0]  keys;
  logic [sktbl_pkg::CAPACITY-1:0][sktbl_pkg::VAL_W-1:0]  vals;

  sktbl_pkg::lookup_t         lookup;
  logic [sktbl_pkg::VAL_W-1:0] hit_val;
  sktbl_pkg::cell_ctrl_t      ctrl;
  logic                       commit;
  logic                       full;
  logic [1:0]                 st_next;

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_UPD) && (!out_valid || out_ready);
  assign full     = (fill == sktbl_pkg::CNT_W'(sktbl_pkg::CAPACITY));

  assign ctrl.cmp = (state == S_CMP);
  assign ctrl.ins = commit && (req == sktbl_pkg::REQ_INSERT) && !lookup.hit && !full;
  assign ctrl.rem = commit && (req == sktbl_pkg::REQ_REMOVE) && lookup.hit;

  always_comb begin
    st_next   = sktbl_pkg::ST_OK;
    fill_next = fill;
    case (req)
      sktbl_pkg::REQ_INSERT: begin
        if (lookup.hit) begin
          st_next = sktbl_pkg::ST_REFUSED;
        end else if (full) begin
          st_next = sktbl_pkg::ST_FULL;
        end else begin
          fill_next = fill + sktbl_pkg::CNT_W'(1);
        end
      end
      sktbl_pkg::REQ_REMOVE: begin
        if (lookup.hit) begin
          fill_next = fill - sktbl_pkg::CNT_W'(1);
        end else begin
          st_next = sktbl_pkg::ST_REFUSED;
        end
      end
      default: begin
        if (!lookup.hit) st_next = sktbl_pkg::ST_REFUSED;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CMP;
      S_CMP:   state_next = S_UPD;
      S_UPD:   if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req     <= req_type;
      req_key <= key;
      req_val <= entry_value;
    end
    if (commit) begin
      status      <= st_next;
      found       <= lookup.hit;
      value_out   <= (lookup.hit && req != sktbl_pkg::REQ_INSERT) ? hit_val : '0;
      position    <= sktbl_pkg::POS_W'(lookup.rank);
      entry_count <= sktbl_pkg::POS_W'(fill_next);
    end
  end

  for (genvar g = 0; g < sktbl_pkg::CAPACITY; g++) begin : g_cell
    logic                              left_lt;
    logic [sktbl_pkg::KEY_W-1:0]       left_key, right_key;
    logic [sktbl_pkg::VAL_W-1:0]       left_val, right_val;

    assign occ[g] = fill > sktbl_pkg::CNT_W'(g);

    if (g == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = req_key;
      assign left_val = req_val;
    end else begin : g_mid
      assign left_lt  = lt[g-1];
      assign left_key = keys[g-1];
      assign left_val = vals[g-1];
    end

    if (g == sktbl_pkg::CAPACITY - 1) begin : g_last
      assign right_key = keys[g];
      assign right_val = vals[g];
    end else begin : g_inner
      assign right_key = keys[g+1];
      assign right_val = vals[g+1];
    end

    sktbl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[g]),
      .req_key   (req_key),
      .req_val   (req_val),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .left_val  (left_val),
      .right_key (right_key),
      .right_val (right_val),
      .lt        (lt[g]),
      .eq        (eq[g]),
      .cell_key  (keys[g]),
      .cell_val  (vals[g])
    );
  end

  sktbl_resolve u_resolve (
    .lt      (lt),
    .eq      (eq),
    .occ     (occ),
    .vals    (vals),
    .fill    (fill),
    .lookup  (lookup),
    .hit_val (hit_val)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= sktbl_pkg::CNT_W'(sktbl_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position <= entry_count)
    else $error("rank beyond entry count");

  a_full_nohit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sktbl_pkg::ST_FULL |-> !found)
    else $error("full status on a present key");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !commit |=> fill == $past(fill))
    else $error("entry count changed outside commit");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request taken while busy");

endmodule
